[rtl/bounded_sequence_with_cursor_unit_defines.svh]
// Assertion macros for the bounded sequence with cursor unit.
// Included by the checker file; no other dependencies.
`ifndef BOUNDED_SEQUENCE_WITH_CURSOR_UNIT_DEFINES_SVH
`define BOUNDED_SEQUENCE_WITH_CURSOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BSCU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BSCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bscu_pkg.sv]
// Shared types and constants for the bounded sequence with cursor unit.
// No dependencies.
`timescale 1ns / 1ps

package bscu_pkg;

    localparam int MAX_IDX_W = 10;

    typedef enum logic [3:0] {
        ACT_INS_FRONT   = 4'd0,
        ACT_INS_REAR    = 4'd1,
        ACT_DEL_FRONT   = 4'd2,
        ACT_DEL_REAR    = 4'd3,
        ACT_INS_CURSOR  = 4'd4,
        ACT_DEL_CURSOR  = 4'd5,
        ACT_SET_POS     = 4'd6,
        ACT_SHIFT       = 4'd7,
        ACT_READ        = 4'd8,
        ACT_WRITE       = 4'd9,
        ACT_CLEAR       = 4'd10
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_INS   = 2'd1,
        CELL_DEL   = 2'd2,
        CELL_WRITE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [MAX_IDX_W-1:0]   pos;
    } cell_ctl_t;

endpackage

[rtl/bscu_cell.sv]
// One storage cell of the element chain: holds one value, shifts with its neighbors.
// Depends on bscu_pkg.
`timescale 1ns / 1ps

module bscu_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int IDX         = 0
) (
    input  logic                   clk,
    input  bscu_pkg::cell_ctl_t    ctl,
    input  logic [VALUE_WIDTH-1:0] din,
    input  logic [VALUE_WIDTH-1:0] prev_q,
    input  logic [VALUE_WIDTH-1:0] next_q,
    input  logic                   sel,
    output logic [VALUE_WIDTH-1:0] q,
    output logic [VALUE_WIDTH-1:0] tap
);

    localparam logic [bscu_pkg::MAX_IDX_W-1:0] MY_IDX = bscu_pkg::MAX_IDX_W'(IDX);

    logic [VALUE_WIDTH-1:0] q_reg;
    logic [VALUE_WIDTH-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        case (ctl.op)
            bscu_pkg::CELL_INS:
            begin
                if (MY_IDX == ctl.pos)
                begin
                    q_next = din;
                end
                else if (MY_IDX > ctl.pos)
                begin
                    q_next = prev_q;
                end
            end
            bscu_pkg::CELL_DEL:
            begin
                if (MY_IDX >= ctl.pos)
                begin
                    q_next = next_q;
                end
            end
            bscu_pkg::CELL_WRITE:
            begin
                if (MY_IDX == ctl.pos)
                begin
                    q_next = din;
                end
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q   = q_reg;
    assign tap = q_reg & {VALUE_WIDTH{sel}};

endmodule

[rtl/bscu_or_tree.sv]
// Registered binary OR tree that gathers the selected cell value.
// No package dependencies; every level of the tree is registered.
`timescale 1ns / 1ps

module bscu_or_tree #(
    parameter int N = 64,
    parameter int W = 32
) (
    input  logic                clk,
    input  logic [N-1:0][W-1:0] leaf,
    output logic [W-1:0]        root
);

    localparam int LV = $clog2(N);
    localparam int P  = 1 << LV;

    logic [P-1:0][W-1:0] lf;
    logic [W-1:0]        node_reg [1:P-1];

    assign lf = (P * W)'(leaf);

    for (genvar i = 1; i < P; i++)
    begin : g_node
        logic [W-1:0] node_next;
        if (i >= P / 2)
        begin : g_bottom
            assign node_next = lf[2 * i - P] | lf[2 * i - P + 1];
        end
        else
        begin : g_inner
            assign node_next = node_reg[2 * i] | node_reg[2 * i + 1];
        end
        always_ff @(posedge clk)
        begin
            node_reg[i] <= node_next;
        end
    end

    assign root = node_reg[1];

endmodule

[rtl/bounded_sequence_with_cursor_unit.sv]
// Channel  | handshake              | payload
// input    | in_valid / in_stall    | action, value, position_arg
// output   | out_valid / out_stall  | read_value, dereferencable, past_rear, before_first,
//          |                        | element_count, cursor_index, status
//
// One transaction at a time. The cell chain, count and cursor update at the accepting edge;
// the value under the cursor then climbs a registered OR tree of clog2(CAPACITY) levels,
// and the result is offered once it reaches the root; a new transaction is taken only after
// that result has been taken. A stalled result holds and keeps in_stall high. Reset leaves
// the sequence empty with the cursor past rear; cell contents are not cleared.
// Top level; depends on bscu_pkg, bscu_cell and bscu_or_tree.
`timescale 1ns / 1ps

module bounded_sequence_with_cursor_unit #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int CUR_W      = CNT_W + 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [3:0]              action,
    input  logic signed [31:0]      value,
    input  logic signed [7:0]       position_arg,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [31:0]      read_value,
    output logic                    dereferencable,
    output logic                    past_rear,
    output logic                    before_first,
    output logic [CNT_W-1:0]        element_count,
    output logic signed [CUR_W-1:0] cursor_index,
    output logic [1:0]              status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LV    = $clog2(CAPACITY);
    localparam int LAT_W = $clog2(LV + 1);
    localparam int AW    = ((CUR_W > 8) ? CUR_W : 8) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_SHOW
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [LAT_W-1:0]        lat_reg;
    logic [LAT_W-1:0]        lat_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic signed [CUR_W-1:0] cursor_reg;
    logic signed [CUR_W-1:0] cursor_next;
    bscu_pkg::status_t       status_reg;
    bscu_pkg::status_t       status_next;

    bscu_pkg::cell_ctl_t     ctl;
    logic                    accept;
    logic                    full;
    logic                    empty;
    logic                    deref;
    logic signed [CUR_W-1:0] count_s;
    logic signed [AW-1:0]    tgt;
    logic signed [AW-1:0]    count_aw;
    logic signed [CUR_W-1:0] clamped;
    logic [VALUE_WIDTH-1:0]  din;
    logic [VALUE_WIDTH-1:0]  root;
    logic [VALUE_WIDTH-1:0]  cell_q [CAPACITY];
    logic [CAPACITY-1:0][VALUE_WIDTH-1:0] taps;

    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign count_s  = $signed({1'b0, count_reg});
    assign deref    = (cursor_reg >= 0) && (cursor_reg < count_s);
    assign count_aw = $signed(AW'(count_reg));

    assign tgt = (bscu_pkg::action_t'(action) == bscu_pkg::ACT_SHIFT)
               ? AW'(cursor_reg) + AW'(position_arg)
               : AW'(position_arg);

    always_comb
    begin
        if (tgt < -1)
        begin
            clamped = '1;
        end
        else if (tgt > count_aw)
        begin
            clamped = count_s;
        end
        else
        begin
            clamped = CUR_W'(tgt);
        end
    end

    if (VALUE_WIDTH <= 32)
    begin : g_narrow
        assign din        = value[VALUE_WIDTH-1:0];
        assign read_value = $signed(32'(root));
    end
    else
    begin : g_wide
        assign din        = {{(VALUE_WIDTH - 32){1'b0}}, value};
        assign read_value = $signed(root[31:0]);
    end

    always_comb
    begin
        ctl         = '{op: bscu_pkg::CELL_HOLD, pos: '0};
        count_next  = count_reg;
        cursor_next = cursor_reg;
        status_next = bscu_pkg::ST_DONE;
        case (bscu_pkg::action_t'(action))
            bscu_pkg::ACT_INS_FRONT:
            begin
                if (full)
                begin
                    status_next = bscu_pkg::ST_FULL;
                end
                else
                begin
                    ctl        = '{op: bscu_pkg::CELL_INS, pos: '0};
                    count_next = count_reg + CNT_W'(1);
                    if (cursor_reg >= 0)
                    begin
                        cursor_next = cursor_reg + CUR_W'(1);
                    end
                end
            end
            bscu_pkg::ACT_INS_REAR:
            begin
                if (full)
                begin
                    status_next = bscu_pkg::ST_FULL;
                end
                else
                begin
                    ctl = '{op: bscu_pkg::CELL_WRITE,
                            pos: bscu_pkg::MAX_IDX_W'(count_reg[IDX_W-1:0])};
                    count_next = count_reg + CNT_W'(1);
                    if (cursor_reg == count_s)
                    begin
                        cursor_next = cursor_reg + CUR_W'(1);
                    end
                end
            end
            bscu_pkg::ACT_DEL_FRONT:
            begin
                if (empty)
                begin
                    status_next = bscu_pkg::ST_IGNORED;
                end
                else
                begin
                    ctl        = '{op: bscu_pkg::CELL_DEL, pos: '0};
                    count_next = count_reg - CNT_W'(1);
                    if (cursor_reg > 0)
                    begin
                        cursor_next = cursor_reg - CUR_W'(1);
                    end
                end
            end
            bscu_pkg::ACT_DEL_REAR:
            begin
                if (empty)
                begin
                    status_next = bscu_pkg::ST_IGNORED;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (cursor_reg == count_s)
                    begin
                        cursor_next = cursor_reg - CUR_W'(1);
                    end
                end
            end
            bscu_pkg::ACT_INS_CURSOR:
            begin
                if (cursor_reg < 0)
                begin
                    status_next = bscu_pkg::ST_IGNORED;
                end
                else if (full)
                begin
                    status_next = bscu_pkg::ST_FULL;
                end
                else
                begin
                    ctl = '{op: bscu_pkg::CELL_INS,
                            pos: bscu_pkg::MAX_IDX_W'(cursor_reg[IDX_W-1:0])};
                    count_next = count_reg + CNT_W'(1);
                end
            end
            bscu_pkg::ACT_DEL_CURSOR:
            begin
                if (!deref)
                begin
                    status_next = bscu_pkg::ST_IGNORED;
                end
                else
                begin
                    ctl = '{op: bscu_pkg::CELL_DEL,
                            pos: bscu_pkg::MAX_IDX_W'(cursor_reg[IDX_W-1:0])};
                    count_next = count_reg - CNT_W'(1);
                end
            end
            bscu_pkg::ACT_SET_POS,
            bscu_pkg::ACT_SHIFT:
            begin
                cursor_next = clamped;
            end
            bscu_pkg::ACT_READ:
            begin
                status_next = bscu_pkg::ST_DONE;
            end
            bscu_pkg::ACT_WRITE:
            begin
                if (!deref)
                begin
                    status_next = bscu_pkg::ST_IGNORED;
                end
                else
                begin
                    ctl = '{op: bscu_pkg::CELL_WRITE,
                            pos: bscu_pkg::MAX_IDX_W'(cursor_reg[IDX_W-1:0])};
                end
            end
            bscu_pkg::ACT_CLEAR:
            begin
                count_next  = '0;
                cursor_next = '0;
            end
            default:
            begin
                status_next = bscu_pkg::ST_IGNORED;
            end
        endcase
        if (!accept)
        begin
            ctl.op = bscu_pkg::CELL_HOLD;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        lat_next   = lat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_WAIT;
                    lat_next   = LAT_W'(LV);
                end
            end
            S_WAIT:
            begin
                lat_next = lat_reg - LAT_W'(1);
                if (lat_reg == LAT_W'(1))
                begin
                    state_next = S_SHOW;
                end
            end
            S_SHOW:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            lat_reg    <= '0;
            count_reg  <= '0;
            cursor_reg <= '0;
            status_reg <= bscu_pkg::ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            lat_reg   <= lat_next;
            if (accept)
            begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
                status_reg <= status_next;
            end
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] prev_q;
        logic [VALUE_WIDTH-1:0] next_q;
        logic                   sel;

        if (i == 0)
        begin : g_first
            assign prev_q = cell_q[i];
        end
        else
        begin : g_prev
            assign prev_q = cell_q[i - 1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_q = cell_q[i];
        end
        else
        begin : g_next
            assign next_q = cell_q[i + 1];
        end

        assign sel = deref && (cursor_reg[IDX_W-1:0] == IDX_W'(i));

        bscu_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .IDX         (i)
        ) u_cell (
            .clk    (clk),
            .ctl    (ctl),
            .din    (din),
            .prev_q (prev_q),
            .next_q (next_q),
            .sel    (sel),
            .q      (cell_q[i]),
            .tap    (taps[i])
        );
    end

    bscu_or_tree #(
        .N (CAPACITY),
        .W (VALUE_WIDTH)
    ) u_tree (
        .clk  (clk),
        .leaf (taps),
        .root (root)
    );

    assign in_stall       = !rst_n || (state_reg != S_IDLE);
    assign out_valid      = (state_reg == S_SHOW);
    assign dereferencable = deref;
    assign past_rear      = (cursor_reg == count_s);
    assign before_first   = (cursor_reg == -1);
    assign element_count  = count_reg;
    assign cursor_index   = cursor_reg;
    assign status         = status_reg;

endmodule

[rtl/bscu_checker.sv]
// Port-level checks for bounded_sequence_with_cursor_unit, bound to the top level.
// Depends on bscu_pkg and bounded_sequence_with_cursor_unit_defines.svh.
`timescale 1ns / 1ps
`include "bounded_sequence_with_cursor_unit_defines.svh"

module bscu_checker #(
    parameter int CAPACITY = 64,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int CUR_W   = CNT_W + 1
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [31:0]      read_value,
    input logic                    dereferencable,
    input logic                    past_rear,
    input logic                    before_first,
    input logic [CNT_W-1:0]        element_count,
    input logic signed [CUR_W-1:0] cursor_index,
    input logic [1:0]              status
);

    `BSCU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(read_value) && $stable(cursor_index) && $stable(status),
        "stalled transaction changed")

    `BSCU_ASSERT_IMPLY(a_one_place, clk, rst_n, out_valid,
        $onehot({dereferencable, past_rear, before_first}),
        "cursor flags not exactly one")

    `BSCU_ASSERT_IMPLY(a_zero_read, clk, rst_n, out_valid && !dereferencable,
        read_value == 0, "nonzero read with no element under cursor")

    `BSCU_ASSERT_IMPLY(a_full_count, clk, rst_n,
        out_valid && (status == bscu_pkg::ST_FULL),
        element_count == CNT_W'(CAPACITY), "refused as full below capacity")

endmodule

bind bounded_sequence_with_cursor_unit bscu_checker #(.CAPACITY(CAPACITY)) u_bscu_checker (.*);
